@@ design/bounded_deque_with_index_defines.svh @@
// Assertion macros shared by the bounded deque RTL.
// No dependencies; included by the modules that carry checks.
`ifndef BOUNDED_DEQUE_WITH_INDEX_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_INDEX_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BDI_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDI_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bdi_pkg.sv @@
// Shared types, codes and defaults for the bounded deque with indexed access.
// No dependencies; imported by every module of the block.
`default_nettype none

package bdi_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OPCODE_W   = 4;
    localparam int VALUE_W    = 32;
    localparam int POSITION_W = 6;
    localparam int DOUT_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = 7;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_READ_INDEX = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_WRITE_INDEX = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_READ_FRONT = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_READ_BACK  = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_CLEAR      = 4'd8;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // Controller to datapath.
    typedef struct packed {
        logic accept;
        logic fill;
    } bdi_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic needs_read;
    } bdi_stat_t;

endpackage

`default_nettype wire

@@ design/bdi_ctrl.sv @@
// Request sequencer of the bounded deque: input and output handshakes and
// the wait for the ring read port. Depends on bdi_pkg and the defines header.
`default_nettype none
`include "bounded_deque_with_index_defines.svh"

module bdi_ctrl
    import bdi_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire bdi_stat_t stat,
    output bdi_cmd_t       cmd
);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_READ = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The output register is free when empty or being taken at this edge.
    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = !((state_reg == S_IDLE) && out_free);
    assign cmd.accept = in_valid && !in_stall;
    assign cmd.fill   = (state_reg == S_READ);
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept)
                begin
                    if (stat.needs_read)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                // The ring data arrives now; the output was emptied at accept.
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `BDI_ASSERT_NXT(a_read_completes, clk, rst_n, state_reg == S_READ, out_valid_reg && state_reg == S_IDLE, "read did not complete into the output")
    `BDI_ASSERT_NXT(a_direct_result, clk, rst_n, cmd.accept && !stat.needs_read, out_valid_reg && state_reg == S_IDLE, "direct result not presented")
    `BDI_ASSERT_NXT(a_read_waits, clk, rst_n, cmd.accept && stat.needs_read, !out_valid_reg && state_reg == S_READ, "read request did not wait for ring data")

endmodule

`default_nettype wire

@@ design/bdi_datapath.sv @@
// Ring memory, front pointer, element count and result registers of the
// bounded deque. Depends on bdi_pkg and the defines header.
`default_nettype none
`include "bounded_deque_with_index_defines.svh"

module bdi_datapath
    import bdi_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bdi_cmd_t              cmd,
    output bdi_stat_t                  stat,
    input  wire logic [OPCODE_W-1:0]   opcode,
    input  wire logic [VALUE_W-1:0]    value,
    input  wire logic [POSITION_W-1:0] position,
    output logic [DOUT_W-1:0]          data_out,
    output logic [STATUS_W-1:0]        status,
    output logic [OCC_W-1:0]           occupancy
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;
    localparam logic [PTR_W:0]   SUM_CAP  = (PTR_W + 1)'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);

    logic [DATA_WIDTH-1:0] ring_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic [PTR_W-1:0]    front_reg;
    logic [PTR_W-1:0]    front_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [DOUT_W-1:0]   data_out_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [OCC_W-1:0]    occ_reg;

    logic                  full;
    logic                  empty;
    logic                  pos_ok;
    logic [PTR_W-1:0]      front_dec;
    logic [PTR_W-1:0]      next_slot;
    logic [PTR_W-1:0]      tail_slot;
    logic [PTR_W-1:0]      back_slot;
    logic [PTR_W-1:0]      pos_slot;
    logic [PTR_W-1:0]      addr;
    logic                  wr_c;
    logic                  rd_c;
    logic [DATA_WIDTH-1:0] wr_data;

    // Ring slot at a given offset from the front; offset is below CAPACITY.
    function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] base,
                                                  input logic [PTR_W-1:0] off);
        logic [PTR_W:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= SUM_CAP)
        begin
            s = s - SUM_CAP;
        end
        return s[PTR_W-1:0];
    endfunction

    assign full      = (count_reg == CNT_FULL);
    assign empty     = (count_reg == '0);
    assign pos_ok    = CMP_W'(position) < CMP_W'(count_reg);
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - 1'b1;
    assign next_slot = ring_slot(front_reg, PTR_W'(1));
    assign tail_slot = ring_slot(front_reg, PTR_W'(count_reg));
    assign back_slot = ring_slot(front_reg, PTR_W'(count_reg - 1'b1));
    assign pos_slot  = ring_slot(front_reg, PTR_W'(position));
    assign wr_data   = DATA_WIDTH'(value);

    always_comb
    begin
        status_next = ST_OK;
        front_next  = front_reg;
        count_next  = count_reg;
        addr        = front_reg;
        wr_c        = 1'b0;
        rd_c        = 1'b0;
        case (opcode)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    front_next = front_dec;
                    addr       = front_dec;
                    wr_c       = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    addr       = tail_slot;
                    wr_c       = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_c       = 1'b1;
                    front_next = next_slot;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    addr       = back_slot;
                    rd_c       = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_READ_INDEX:
            begin
                if (!pos_ok)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    addr = pos_slot;
                    rd_c = 1'b1;
                end
            end
            OP_WRITE_INDEX:
            begin
                if (!pos_ok)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    addr = pos_slot;
                    wr_c = 1'b1;
                end
            end
            OP_READ_FRONT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_c = 1'b1;
                end
            end
            OP_READ_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    addr = back_slot;
                    rd_c = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                front_next = '0;
                count_next = '0;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign stat.needs_read = rd_c;

    // Single-port ring: one write or one registered read per request.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_c)
        begin
            ring_mem[addr] <= wr_data;
        end
        if (cmd.accept && rd_c)
        begin
            rd_data_reg <= ring_mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            status_reg   <= status_next;
            occ_reg      <= OCC_W'(count_next);
            data_out_reg <= '0;
        end
        else if (cmd.fill)
        begin
            data_out_reg <= DOUT_W'(rd_data_reg);
        end
    end

    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign occupancy = occ_reg;

    `BDI_ASSERT_IMP(a_count_bounded, clk, rst_n, 1'b1, count_reg <= CNT_FULL, "element count above capacity")
    `BDI_ASSERT_NXT(a_clear_resets, clk, rst_n, cmd.accept && opcode == OP_CLEAR, count_reg == '0 && front_reg == '0, "clear left pointer or count set")
    `BDI_ASSERT_NXT(a_full_holds, clk, rst_n, cmd.accept && status_next == ST_FULL, $stable(count_reg) && $stable(front_reg), "rejected push changed the queue")

endmodule

`default_nettype wire

@@ design/bounded_deque_with_index.sv @@
// A push, write, clear or rejected request shows its result in the cycle after
// acceptance; a pop or read goes through the single-port ring's registered read
// port, then the output register. One request per cycle without ring reads while
// the output is not stalled; a pop or read stalls input until its data is output.
// Reset clears the front pointer and count; ring contents are not cleared.
`default_nettype none

module bounded_deque_with_index
    import bdi_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [OPCODE_W-1:0]   opcode,
    input  wire logic [VALUE_W-1:0]    value,
    input  wire logic [POSITION_W-1:0] position,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [DOUT_W-1:0]          data_out,
    output logic [STATUS_W-1:0]        status,
    output logic [OCC_W-1:0]           occupancy
);

    bdi_cmd_t  cmd;
    bdi_stat_t stat;

    bdi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    bdi_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .opcode    (opcode),
        .value     (value),
        .position  (position),
        .data_out  (data_out),
        .status    (status),
        .occupancy (occupancy)
    );

endmodule

`default_nettype wire

@@ sim/tb_bounded_deque_with_index.sv @@
// Self-checking testbench for bounded_deque_with_index: directed and random request words,
// with a ring-buffer predictor, a clocked driver and a clocked response monitor.
// Depends on bdi_pkg and the bounded_deque_with_index RTL.
`default_nettype none

module tb_bounded_deque_with_index;
    import bdi_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int PTR_W        = $clog2(DEPTH);
    localparam logic [POSITION_W-1:0] POS_MAX = '1;
    localparam int RANDOM_WORDS = 730;
    localparam int QUIET_TAIL   = 80;
    localparam int STALL_LIMIT  = 500;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [OPCODE_W-1:0] OP_SPARE_FIRST = OP_CLEAR + 1'b1;
    localparam logic [OPCODE_W-1:0] OP_SPARE_LAST  = '1;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} traffic_mode_t;

    typedef struct {
        logic [OPCODE_W-1:0]   op;
        logic [VALUE_W-1:0]    value;
        logic [POSITION_W-1:0] pos;
        bit                    hold;
    } deque_request_t;

    typedef struct packed {
        logic [DOUT_W-1:0]   data;
        logic [STATUS_W-1:0] st;
        logic [OCC_W-1:0]    occ;
    } deque_reply_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OPCODE_W-1:0]   opcode = '0;
    logic [VALUE_W-1:0]    value = '0;
    logic [POSITION_W-1:0] position = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DOUT_W-1:0]     data_out;
    logic [STATUS_W-1:0]   status;
    logic [OCC_W-1:0]      occupancy;

    deque_request_t request_queue[$];
    deque_reply_t   awaited_replies[$];

    // Predictor state: a copy of the ring, its front pointer and its count.
    logic [DOUT_W-1:0] ring_copy[DEPTH];
    logic [PTR_W-1:0]  ring_front = '0;
    logic [OCC_W-1:0]  ring_held = '0;

    int  gen_count = 0;
    int  error_count = 0;
    int  quiet_cycles = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;
    bit  in_taken = 1'b0;

    bounded_deque_with_index u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data_out  (data_out),
        .status    (status),
        .occupancy (occupancy)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic deque_reply_t apply_request(deque_request_t req);
        deque_reply_t     rep;
        logic [PTR_W-1:0] slot;
        logic [OCC_W-1:0] last;
        rep.data = '0;
        rep.st = ST_OK;
        last = ring_held - 1'b1;
        case (req.op)
            OP_PUSH_FRONT:
                if (ring_held == DEPTH)
                    rep.st = ST_FULL;
                else
                begin
                    ring_front = ring_front - 1'b1;
                    ring_copy[ring_front] = req.value;
                    ring_held = ring_held + 1'b1;
                end
            OP_PUSH_BACK:
                if (ring_held == DEPTH)
                    rep.st = ST_FULL;
                else
                begin
                    slot = ring_front + ring_held[PTR_W-1:0];
                    ring_copy[slot] = req.value;
                    ring_held = ring_held + 1'b1;
                end
            OP_POP_FRONT:
                if (ring_held == 0)
                    rep.st = ST_EMPTY;
                else
                begin
                    rep.data = ring_copy[ring_front];
                    ring_front = ring_front + 1'b1;
                    ring_held = ring_held - 1'b1;
                end
            OP_POP_BACK:
                if (ring_held == 0)
                    rep.st = ST_EMPTY;
                else
                begin
                    slot = ring_front + last[PTR_W-1:0];
                    rep.data = ring_copy[slot];
                    ring_held = ring_held - 1'b1;
                end
            OP_READ_INDEX:
                if ({1'b0, req.pos} >= ring_held)
                    rep.st = ST_RANGE;
                else
                begin
                    slot = ring_front + req.pos;
                    rep.data = ring_copy[slot];
                end
            OP_WRITE_INDEX:
                if ({1'b0, req.pos} >= ring_held)
                    rep.st = ST_RANGE;
                else
                begin
                    slot = ring_front + req.pos;
                    ring_copy[slot] = req.value;
                end
            OP_READ_FRONT:
                if (ring_held == 0)
                    rep.st = ST_EMPTY;
                else
                    rep.data = ring_copy[ring_front];
            OP_READ_BACK:
                if (ring_held == 0)
                    rep.st = ST_EMPTY;
                else
                begin
                    slot = ring_front + last[PTR_W-1:0];
                    rep.data = ring_copy[slot];
                end
            OP_CLEAR:
            begin
                ring_front = '0;
                ring_held = '0;
            end
            default:
                ;
        endcase
        rep.occ = ring_held;
        return rep;
    endfunction

    // Queues one request word and keeps a rough element count so that
    // random positions can be aimed inside the held range.
    task automatic add_request(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val,
                               input logic [POSITION_W-1:0] pos, input bit hold);
        deque_request_t req;
        req.op = op;
        req.value = val;
        req.pos = pos;
        req.hold = hold;
        request_queue.push_back(req);
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
                if (gen_count < DEPTH)
                    gen_count++;
            OP_POP_FRONT, OP_POP_BACK:
                if (gen_count > 0)
                    gen_count--;
            OP_CLEAR:
                gen_count = 0;
            default:
                ;
        endcase
    endtask

    function automatic deque_request_t draw_request(traffic_mode_t mode);
        deque_request_t req;
        int             pick;
        pick = $urandom_range(0, 99);
        req.value = $urandom();
        req.hold = ($urandom_range(0, 149) == 0);
        if (gen_count > 0 && $urandom_range(0, 9) < 7)
            req.pos = POSITION_W'($urandom_range(0, gen_count - 1));
        else
            req.pos = POSITION_W'($urandom_range(0, POS_MAX));
        case (mode)
            MODE_FILL:
                req.op = (pick < 42) ? OP_PUSH_FRONT : (pick < 85) ? OP_PUSH_BACK :
                         (pick < 93) ? OP_READ_INDEX : OP_WRITE_INDEX;
            MODE_DRAIN:
                req.op = (pick < 38) ? OP_POP_FRONT : (pick < 76) ? OP_POP_BACK :
                         (pick < 86) ? OP_READ_FRONT : (pick < 93) ? OP_READ_INDEX :
                         OP_WRITE_INDEX;
            MODE_MIXED:
                req.op = (pick < 25) ? OP_READ_INDEX : (pick < 45) ? OP_WRITE_INDEX :
                         (pick < 55) ? OP_READ_FRONT : (pick < 65) ? OP_READ_BACK :
                         (pick < 75) ? OP_PUSH_FRONT : (pick < 85) ? OP_PUSH_BACK :
                         (pick < 92) ? OP_POP_FRONT : OP_POP_BACK;
            default:
                req.op = OPCODE_W'($urandom_range(0, OP_SPARE_LAST));
        endcase
        return req;
    endfunction

    task automatic build_directed_requests;
        // Empty-deque cases first, then a fill, index access, partial drain and clear.
        add_request(OP_READ_FRONT, '0, '0, 1'b0);
        add_request(OP_READ_BACK, '0, '0, 1'b0);
        add_request(OP_POP_FRONT, '0, '0, 1'b0);
        add_request(OP_POP_BACK, '0, '0, 1'b0);
        add_request(OP_READ_INDEX, '0, '0, 1'b0);
        add_request(OP_WRITE_INDEX, 32'hDEAD_BEEF, POS_MAX, 1'b0);
        add_request(OP_SPARE_FIRST, '1, POS_MAX, 1'b0);
        add_request(OP_SPARE_LAST, '1, POS_MAX, 1'b0);
        add_request(OP_PUSH_BACK, '1, '0, 1'b0);
        add_request(OP_PUSH_FRONT, '0, POS_MAX, 1'b0);
        add_request(OP_PUSH_BACK, 32'hA5A5_A5A5, '0, 1'b0);
        add_request(OP_READ_INDEX, '0, 6'd0, 1'b0);
        add_request(OP_READ_INDEX, '0, 6'd2, 1'b0);
        add_request(OP_READ_INDEX, '0, 6'd3, 1'b0);
        add_request(OP_WRITE_INDEX, 32'h5A5A_5A5A, 6'd1, 1'b0);
        add_request(OP_READ_INDEX, '0, 6'd1, 1'b0);
        add_request(OP_READ_FRONT, '0, '0, 1'b0);
        add_request(OP_READ_BACK, '0, '0, 1'b0);
        add_request(OP_POP_BACK, '0, '0, 1'b0);
        add_request(OP_POP_FRONT, '0, '0, 1'b0);
        add_request(OP_PUSH_FRONT, '1, '0, 1'b1);
        add_request(OP_CLEAR, '1, POS_MAX, 1'b0);
        add_request(OP_READ_FRONT, '0, '0, 1'b0);
        add_request(OP_POP_BACK, '0, '0, 1'b0);
        add_request(OP_WRITE_INDEX, '1, POS_MAX, 1'b0);
    endtask

    task automatic build_random_requests;
        deque_request_t req;
        traffic_mode_t  mode;
        int             counted;
        int             pick;
        int             seg_len;
        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            mode = (pick < 30) ? MODE_FILL : (pick < 55) ? MODE_DRAIN :
                   (pick < 90) ? MODE_MIXED : MODE_NOISE;
            seg_len = $urandom_range(10, 100);
            repeat (seg_len)
            begin
                req = draw_request(mode);
                add_request(req.op, req.value, req.pos, req.hold);
                if (req.op <= OP_CLEAR)
                    counted++;
            end
        end
    endtask

    // Driver: a presented word holds until it is taken.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            send_calm = ~send_calm;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            in_taken = 1'b0;
            if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (request_queue.size() == 0 ||
                     (request_queue[0].hold && awaited_replies.size() != 0))
                in_valid <= 1'b0;
            else if (request_queue.size() > QUIET_TAIL && !send_calm &&
                     $urandom_range(0, 7) == 0)
            begin
                send_gap = $urandom_range(0, 9);
                in_valid <= 1'b0;
            end
            else
            begin
                in_valid <= 1'b1;
                opcode <= request_queue[0].op;
                value <= request_queue[0].value;
                position <= request_queue[0].pos;
            end
        end
    end

    // Receiver back-pressure in bursts, none in the tail of the run.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            recv_calm = ~recv_calm;
        if (!rst_n || request_queue.size() <= QUIET_TAIL)
            out_stall <= 1'b0;
        else if (recv_gap != 0)
        begin
            recv_gap--;
            out_stall <= 1'b1;
        end
        else if (!recv_calm && $urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 9);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Monitor: predicts on every accepted request and checks every accepted reply.
    always @(posedge clk)
    begin
        deque_request_t seen;
        deque_reply_t   want;
        bit             moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (in_valid && !in_stall)
            begin
                seen.op = opcode;
                seen.value = value;
                seen.pos = position;
                seen.hold = 1'b0;
                awaited_replies.push_back(apply_request(seen));
                void'(request_queue.pop_front());
                in_taken = 1'b1;
                moved = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (awaited_replies.size() == 0)
                    report_mismatch("unexpected word", data_out, '0);
                else
                begin
                    want = awaited_replies.pop_front();
                    if (data_out !== want.data)
                        report_mismatch("data_out", data_out, want.data);
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (occupancy !== want.occ)
                        report_mismatch("occupancy", 32'(occupancy), 32'(want.occ));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb_bounded_deque_with_index: errors");
        $finish;
    end

    initial
    begin
        build_directed_requests();
        build_random_requests();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (request_queue.size() != 0 || awaited_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_replies.size() != 0)
            report_mismatch("words never returned", awaited_replies.size(), 0);
        if (error_count == 0)
            $display("tb_bounded_deque_with_index: clean");
        else
            $display("tb_bounded_deque_with_index: errors");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/bdi_pkg.sv
design/bdi_ctrl.sv
design/bdi_datapath.sv
design/bounded_deque_with_index.sv
sim/tb_bounded_deque_with_index.sv
